/* hw/rtl/cssc_pkg.sv */
// shared types and constants of the clipped square spiral scan core
package cssc_pkg;

    // field widths
    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;

    // default largest frame dimension
    localparam int MAX_DIM_DEF = 4096;

    // frame size after reset
    localparam int FRAME_W_RST = 640;
    localparam int FRAME_H_RST = 480;

    // configuration register indexes
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    // input item kinds
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    // ring sides, visited in increasing order with wraparound
    typedef enum logic [1:0] {
        SIDE_TOP    = 2'd0,
        SIDE_RIGHT  = 2'd1,
        SIDE_BOTTOM = 2'd2,
        SIDE_LEFT   = 2'd3
    } t_side;

    // walking directions
    typedef enum logic [1:0] {
        DIR_DOWN  = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_UP    = 2'd2,
        DIR_RIGHT = 2'd3
    } t_dir;

endpackage

/* hw/rtl/clipped_square_spiral_scan_core.sv */
// top level of the clipped square spiral scan core
//
// Emits pixel coordinates in square rings spiraling outward from a start point, clipped
// to the configured frame. A start transaction clamps the start point into the frame and
// emits it; each advance transaction emits the next pixel of the ring (right side down,
// bottom row left, left side up, top row right), with line_end on the last pixel of each
// side. Sides whose edge lies outside the frame are skipped; once every edge is out,
// advances return finished with zero coordinates until the next start. One transaction is
// accepted every clock while the output register is not stalled, and its result is
// registered there; the next ring side is picked by a four-way rotating priority over the
// edge-in-frame checks, so a side change does not hold up the scan. Frame size writes are
// clamped to 1..MAX_DIM when they are taken and apply to the next side chosen.
module clipped_square_spiral_scan_core #(
    parameter int MAX_DIM = cssc_pkg::MAX_DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_kind,
    input  logic [cssc_pkg::COORD_W-1:0]  i_start_x,
    input  logic [cssc_pkg::COORD_W-1:0]  i_start_y,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [cssc_pkg::COORD_W-1:0]  o_pixel_x,
    output logic [cssc_pkg::COORD_W-1:0]  o_pixel_y,
    output logic                          o_line_end,
    output logic                          o_finished,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [cssc_pkg::DIM_W-1:0]    i_cfg_data
);

    // edge width holds -1 .. MAX_DIM signed, position width holds 0 .. MAX_DIM
    localparam int EW   = $clog2(MAX_DIM + 1) + 1;
    localparam int PW   = EW - 1;
    localparam int CMPW = (EW > cssc_pkg::DIM_W + 1) ? EW : cssc_pkg::DIM_W + 1;
    localparam int RST_W = (cssc_pkg::FRAME_W_RST > MAX_DIM) ? MAX_DIM : cssc_pkg::FRAME_W_RST;
    localparam int RST_H = (cssc_pkg::FRAME_H_RST > MAX_DIM) ? MAX_DIM : cssc_pkg::FRAME_H_RST;

    // effective frame size
    logic [PW-1:0]          r_frame_w;
    logic [PW-1:0]          r_frame_h;
    logic [CMPW-1:0]        cfg_ext;
    logic [PW-1:0]          cfg_eff;

    // spiral state
    logic signed [EW-1:0]   r_left, r_right, r_top, r_bottom;
    logic signed [EW-1:0]   n_left, n_right, n_top, n_bottom;
    cssc_pkg::t_side        r_side, n_side;
    cssc_pkg::t_dir         r_dir, n_dir;
    logic [PW-1:0]          r_walk_x, r_walk_y, n_walk_x, n_walk_y;
    logic [PW-1:0]          r_pl, n_pl;
    logic                   r_running, n_running;

    // result register
    logic                   r_out_valid;
    logic [cssc_pkg::COORD_W-1:0] r_pixel_x, r_pixel_y, n_pixel_x, n_pixel_y;
    logic                   r_line_end, r_finished, n_line_end, n_finished;

    // step logic
    logic                   accept;
    logic signed [EW-1:0]   frame_w_s, frame_h_s;
    logic [3:0]             side_ok;
    logic                   sel_found;
    cssc_pkg::t_side        sel_side;
    cssc_pkg::t_side        probe;
    logic [CMPW-1:0]        sx_ext, sy_ext, wm1, hm1, x0_c, y0_c;
    logic signed [EW-1:0]   x0_e, y0_e;
    logic signed [EW-1:0]   hcnt, vcnt;
    logic [PW-1:0]          cur_x, cur_y, cur_pl;
    cssc_pkg::t_dir         cur_dir;
    logic                   use_walk;

    // handshakes
    assign accept      = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid = r_out_valid;
    assign o_pixel_x   = r_pixel_x;
    assign o_pixel_y   = r_pixel_y;
    assign o_line_end  = r_line_end;
    assign o_finished  = r_finished;

    // clamp of a frame size write to 1 .. MAX_DIM
    always_comb begin
        cfg_ext = CMPW'(i_cfg_data);
        if (cfg_ext == '0) begin
            cfg_eff = PW'(1);
        end else if (cfg_ext > CMPW'(MAX_DIM)) begin
            cfg_eff = PW'(MAX_DIM);
        end else begin
            cfg_eff = PW'(cfg_ext);
        end
    end

    // frame size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= PW'(RST_W);
            r_frame_h <= PW'(RST_H);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                cssc_pkg::CFG_FRAME_WIDTH:  r_frame_w <= cfg_eff;
                cssc_pkg::CFG_FRAME_HEIGHT: r_frame_h <= cfg_eff;
                default: ;
            endcase
        end
    end

    // side selection: which edges are still inside the frame
    assign frame_w_s = $signed({1'b0, r_frame_w});
    assign frame_h_s = $signed({1'b0, r_frame_h});
    assign side_ok[cssc_pkg::SIDE_TOP]    = !r_top[EW-1];
    assign side_ok[cssc_pkg::SIDE_RIGHT]  = r_right < frame_w_s;
    assign side_ok[cssc_pkg::SIDE_BOTTOM] = r_bottom < frame_h_s;
    assign side_ok[cssc_pkg::SIDE_LEFT]   = !r_left[EW-1];

    // rotating priority starting after the current side
    always_comb begin
        sel_found = 1'b0;
        sel_side  = r_side;
        probe     = r_side;
        for (int j = 4; j >= 1; j--) begin
            probe = cssc_pkg::t_side'(r_side + 2'(j));
            if (side_ok[probe]) begin
                sel_found = 1'b1;
                sel_side  = probe;
            end
        end
    end

    // start point clamp
    always_comb begin
        sx_ext = CMPW'(i_start_x);
        sy_ext = CMPW'(i_start_y);
        wm1    = CMPW'(r_frame_w) - CMPW'(1);
        hm1    = CMPW'(r_frame_h) - CMPW'(1);
        x0_c   = (sx_ext > wm1) ? wm1 : sx_ext;
        y0_c   = (sy_ext > hm1) ? hm1 : sy_ext;
        x0_e   = $signed(EW'(x0_c));
        y0_e   = $signed(EW'(y0_c));
    end

    // side lengths
    assign hcnt = r_right - r_left - EW'(1);
    assign vcnt = r_bottom - r_top - EW'(1);

    // next state and result
    always_comb begin
        n_left     = r_left;
        n_right    = r_right;
        n_top      = r_top;
        n_bottom   = r_bottom;
        n_side     = r_side;
        n_dir      = r_dir;
        n_walk_x   = r_walk_x;
        n_walk_y   = r_walk_y;
        n_pl       = r_pl;
        n_running  = r_running;
        n_pixel_x  = '0;
        n_pixel_y  = '0;
        n_line_end = 1'b0;
        n_finished = 1'b1;
        cur_x      = r_walk_x;
        cur_y      = r_walk_y;
        cur_dir    = r_dir;
        cur_pl     = r_pl;
        use_walk   = 1'b0;

        if (i_kind == cssc_pkg::KIND_START) begin
            // start point is the single pixel of the first right side
            n_left     = x0_e - EW'(1);
            n_right    = x0_e + EW'(1);
            n_top      = y0_e - EW'(1);
            n_bottom   = y0_e + EW'(1);
            n_side     = cssc_pkg::SIDE_RIGHT;
            n_dir      = cssc_pkg::DIR_DOWN;
            n_walk_x   = PW'(x0_c);
            n_walk_y   = PW'(y0_c) + PW'(1);
            n_pl       = '0;
            n_running  = 1'b1;
            n_pixel_x  = cssc_pkg::COORD_W'(x0_c);
            n_pixel_y  = cssc_pkg::COORD_W'(y0_c);
            n_line_end = 1'b1;
            n_finished = 1'b0;
        end else if (r_running) begin
            if (r_pl != '0) begin
                use_walk = 1'b1;
            end else if (!sel_found) begin
                // every edge out of the frame
                n_running = 1'b0;
                n_pl      = '0;
            end else begin
                // open the next side in the frame
                use_walk = 1'b1;
                n_side   = sel_side;
                case (sel_side)
                    cssc_pkg::SIDE_TOP: begin
                        cur_pl  = PW'(hcnt);
                        cur_x   = PW'(r_left + EW'(1));
                        cur_y   = PW'(r_top);
                        cur_dir = cssc_pkg::DIR_RIGHT;
                        n_top   = r_top - EW'(1);
                    end
                    cssc_pkg::SIDE_RIGHT: begin
                        cur_pl  = PW'(vcnt);
                        cur_x   = PW'(r_right);
                        cur_y   = PW'(r_top + EW'(1));
                        cur_dir = cssc_pkg::DIR_DOWN;
                        n_right = r_right + EW'(1);
                    end
                    cssc_pkg::SIDE_BOTTOM: begin
                        cur_pl   = PW'(hcnt);
                        cur_x    = PW'(r_right - EW'(1));
                        cur_y    = PW'(r_bottom);
                        cur_dir  = cssc_pkg::DIR_LEFT;
                        n_bottom = r_bottom + EW'(1);
                    end
                    default: begin
                        cur_pl  = PW'(vcnt);
                        cur_x   = PW'(r_left);
                        cur_y   = PW'(r_bottom - EW'(1));
                        cur_dir = cssc_pkg::DIR_UP;
                        n_left  = r_left - EW'(1);
                    end
                endcase
            end

            // emit the current pixel and step along the side
            if (use_walk) begin
                n_pixel_x  = cssc_pkg::COORD_W'(cur_x);
                n_pixel_y  = cssc_pkg::COORD_W'(cur_y);
                n_line_end = (cur_pl == PW'(1));
                n_finished = 1'b0;
                n_pl       = cur_pl - PW'(1);
                n_dir      = cur_dir;
                n_walk_x   = cur_x;
                n_walk_y   = cur_y;
                case (cur_dir)
                    cssc_pkg::DIR_DOWN:  n_walk_y = cur_y + PW'(1);
                    cssc_pkg::DIR_LEFT:  n_walk_x = cur_x - PW'(1);
                    cssc_pkg::DIR_UP:    n_walk_y = cur_y - PW'(1);
                    default:             n_walk_x = cur_x + PW'(1);
                endcase
            end
        end
    end

    // spiral state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= -EW'(1);
            r_right   <= '0;
            r_top     <= -EW'(1);
            r_bottom  <= '0;
            r_side    <= cssc_pkg::SIDE_TOP;
            r_dir     <= cssc_pkg::DIR_DOWN;
            r_walk_x  <= '0;
            r_walk_y  <= '0;
            r_pl      <= '0;
            r_running <= 1'b0;
        end else if (accept) begin
            r_left    <= n_left;
            r_right   <= n_right;
            r_top     <= n_top;
            r_bottom  <= n_bottom;
            r_side    <= n_side;
            r_dir     <= n_dir;
            r_walk_x  <= n_walk_x;
            r_walk_y  <= n_walk_y;
            r_pl      <= n_pl;
            r_running <= n_running;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pixel_x  <= n_pixel_x;
            r_pixel_y  <= n_pixel_y;
            r_line_end <= n_line_end;
            r_finished <= n_finished;
        end
    end

endmodule

/* verif/tb_clipped_square_spiral_scan_core.sv */
// self-checking testbench of the clipped square spiral scan core
module tb_clipped_square_spiral_scan_core;
    timeunit 1ns;
    timeprecision 1ps;

    import cssc_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RAND_ITEMS  = 1500;
    localparam int DIR_ROWS    = 31;

    // one emitted pixel
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               line_end;
        logic               finished;
    } pixel_t;

    // directed stimulus row: an item or a register write
    typedef enum logic {ROW_ITEM, ROW_CFG} row_op_t;

    typedef struct packed {
        row_op_t            op;
        logic               kind;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic               cfg_idx;
        logic [DIM_W-1:0]   cfg_data;
        logic               typed;
        pixel_t             want;
    } stim_row_t;

    localparam pixel_t PIX_DONE = {12'd0, 12'd0, 1'b0, 1'b1};
    localparam pixel_t PIX_NONE = '0;

    // dut ports
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    logic               i_kind      = KIND_ADVANCE;
    logic [COORD_W-1:0] i_start_x   = '0;
    logic [COORD_W-1:0] i_start_y   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [COORD_W-1:0] o_pixel_x;
    logic [COORD_W-1:0] o_pixel_y;
    logic               o_line_end;
    logic               o_finished;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_index = CFG_FRAME_WIDTH;
    logic [DIM_W-1:0]   i_cfg_data  = '0;

    // expected pixels in order, and bookkeeping
    pixel_t pending_pixels [$];
    int     err_cnt    = 0;
    int     n_accepted = 0;
    int     n_sent     = 0;
    int     cycle_cnt  = 0;
    logic   row_typed  = 1'b0;
    pixel_t row_want   = '0;

    // scan state of the predictor
    logic [DIM_W-1:0]        frame_w_q;
    logic [DIM_W-1:0]        frame_h_q;
    logic signed [13:0]      left_e;
    logic signed [13:0]      right_e;
    logic signed [13:0]      top_e;
    logic signed [13:0]      bottom_e;
    t_side                   side_q;
    logic [COORD_W-1:0]      walk_x;
    logic [COORD_W-1:0]      walk_y;
    logic [DIM_W-1:0]        pix_left;
    t_dir                    walk_dir;
    bit                      scan_on;

    // frame size as used by the block, kept by the stimulus side
    logic [DIM_W-1:0] drv_w = DIM_W'(FRAME_W_RST);
    logic [DIM_W-1:0] drv_h = DIM_W'(FRAME_H_RST);

    clipped_square_spiral_scan_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_line_end  (o_line_end),
        .o_finished  (o_finished),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // register value limited to 1..MAX_DIM
    function automatic int frame_span(logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
        return int'(v);
    endfunction

    function automatic void scan_reset();
        frame_w_q = DIM_W'(FRAME_W_RST);
        frame_h_q = DIM_W'(FRAME_H_RST);
        left_e    = -14'sd1;
        right_e   = 14'sd0;
        top_e     = -14'sd1;
        bottom_e  = 14'sd0;
        side_q    = SIDE_TOP;
        walk_x    = '0;
        walk_y    = '0;
        pix_left  = '0;
        walk_dir  = DIR_DOWN;
        scan_on   = 1'b0;
    endfunction

    // rotate to the next ring side that still holds pixels in the frame
    function automatic bit pick_next_side();
        int w;
        int h;
        int cnt;
        w = frame_span(frame_w_q);
        h = frame_span(frame_h_q);
        for (int i = 0; i < 8; i++) begin
            cnt = 0;
            if (!(top_e >= 0 || right_e < w || bottom_e < h || left_e >= 0))
                return 1'b0;
            side_q = t_side'(side_q + 2'd1);
            case (side_q)
                SIDE_TOP: if (top_e >= 0) begin
                    cnt      = int'(right_e) - int'(left_e) - 1;
                    walk_x   = 12'(left_e + 14'sd1);
                    walk_y   = 12'(top_e);
                    walk_dir = DIR_RIGHT;
                    top_e    = top_e - 14'sd1;
                end
                SIDE_RIGHT: if (right_e < w) begin
                    cnt      = int'(bottom_e) - int'(top_e) - 1;
                    walk_x   = 12'(right_e);
                    walk_y   = 12'(top_e + 14'sd1);
                    walk_dir = DIR_DOWN;
                    right_e  = right_e + 14'sd1;
                end
                SIDE_BOTTOM: if (bottom_e < h) begin
                    cnt      = int'(right_e) - int'(left_e) - 1;
                    walk_x   = 12'(right_e - 14'sd1);
                    walk_y   = 12'(bottom_e);
                    walk_dir = DIR_LEFT;
                    bottom_e = bottom_e + 14'sd1;
                end
                default: if (left_e >= 0) begin
                    cnt      = int'(bottom_e) - int'(top_e) - 1;
                    walk_x   = 12'(left_e);
                    walk_y   = 12'(bottom_e - 14'sd1);
                    walk_dir = DIR_UP;
                    left_e   = left_e - 14'sd1;
                end
            endcase
            if (cnt >= 1) begin
                pix_left = 13'(cnt);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // pixel that one accepted transaction produces
    function automatic pixel_t next_scan_pixel(logic kind, logic [COORD_W-1:0] sx,
                                               logic [COORD_W-1:0] sy);
        pixel_t r;
        int     x0;
        int     y0;
        r = PIX_DONE;
        if (kind == KIND_START) begin
            x0 = int'(sx);
            y0 = int'(sy);
            // clamp start point into the frame
            if (x0 > frame_span(frame_w_q) - 1) x0 = frame_span(frame_w_q) - 1;
            if (y0 > frame_span(frame_h_q) - 1) y0 = frame_span(frame_h_q) - 1;
            left_e   = 14'(x0 - 1);
            right_e  = 14'(x0);
            top_e    = 14'(y0 - 1);
            bottom_e = 14'(y0 + 1);
            side_q   = SIDE_TOP;
            pix_left = '0;
            scan_on  = 1'b1;
        end
        if (!scan_on) return r;
        if (pix_left == 0) begin
            if (!pick_next_side()) begin
                scan_on  = 1'b0;
                pix_left = '0;
                return r;
            end
        end
        r.x        = walk_x;
        r.y        = walk_y;
        r.line_end = (pix_left == 1);
        r.finished = 1'b0;
        pix_left   = pix_left - 13'd1;
        case (walk_dir)
            DIR_DOWN:  walk_y = walk_y + 12'd1;
            DIR_LEFT:  walk_x = walk_x - 12'd1;
            DIR_UP:    walk_y = walk_y - 12'd1;
            default:   walk_x = walk_x + 12'd1;
        endcase
        return r;
    endfunction

    task automatic flag_error(string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("%0t ns: %s", $time, msg);
    endtask

    // follow register writes and accepted transactions
    always @(posedge i_clk) begin : predict_blk
        pixel_t want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_FRAME_WIDTH) frame_w_q = i_cfg_data;
                else frame_h_q = i_cfg_data;
            end
            if (i_in_valid && !o_in_stall) begin
                want = next_scan_pixel(i_kind, i_start_x, i_start_y);
                if (row_typed) want = row_want;
                pending_pixels.push_back(want);
                n_accepted++;
            end
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin : check_blk
        pixel_t got;
        pixel_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_pixel_x, o_pixel_y, o_line_end, o_finished};
            if (pending_pixels.size() == 0) begin
                flag_error($sformatf("unexpected result x=%0d y=%0d line_end=%0b finished=%0b",
                                     got.x, got.y, got.line_end, got.finished));
            end else begin
                want = pending_pixels.pop_front();
                if (got !== want)
                    flag_error($sformatf({"mismatch: expected x=%0d y=%0d line_end=%0b ",
                                          "finished=%0b, got x=%0d y=%0d line_end=%0b ",
                                          "finished=%0b"},
                                         want.x, want.y, want.line_end, want.finished,
                                         got.x, got.y, got.line_end, got.finished));
            end
        end
    end

    // receiver: random stalls, plus two long hold-offs that back the block up
    initial begin : out_stall_gen
        int mode;
        int seg_len;
        int holds_done;
        holds_done = 0;
        @(posedge i_clk);
        forever begin
            if ((holds_done == 0 && n_accepted >= 300) ||
                (holds_done == 1 && n_accepted >= 1000)) begin
                holds_done++;
                for (int c = 0; c < 200; c++) begin
                    i_out_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end else begin
                mode    = $urandom_range(0, 9);
                seg_len = (mode == 9) ? $urandom_range(10, 50) : $urandom_range(1, 24);
                for (int c = 0; c < seg_len; c++) begin
                    case (mode)
                        0, 1, 2, 3: i_out_stall <= 1'b0;
                        9:          i_out_stall <= 1'b1;
                        default:    i_out_stall <= ($urandom_range(0, 2) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // run ends here if the block hangs
    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // gap length before an item: mostly short, a few long
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return 13'd1;
            2:       return 13'(MAX_DIM_DEF);
            3:       return '1;
            4:       return 13'($urandom());
            default: return 13'($urandom_range(1, 16));
        endcase
    endfunction

    task automatic idle_in(int cycles);
        if (cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic send_item(logic kind, logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                             logic typed, pixel_t want);
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_start_x  <= sx;
        i_start_y  <= sy;
        row_typed  <= typed;
        row_want   <= want;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        n_sent++;
    endtask

    // frame registers change only once every expected pixel is out
    task automatic write_frame_reg(logic idx, logic [DIM_W-1:0] val);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_pixels.size() != 0);
        repeat (2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_FRAME_WIDTH) drv_w = val;
        else drv_h = val;
    endtask

    // directed rows: idle advance, corners, clamping, tiny and huge frames,
    // frame change in the middle of a spiral, a complete small spiral
    stim_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_ITEM, KIND_ADVANCE, 12'hFFF, 12'hFFF, 1'b0, 13'd0, 1'b1, PIX_DONE},
        '{ROW_ITEM, KIND_START, 12'd0, 12'd0, 1'b0, 13'd0, 1'b1,
          {12'd0, 12'd0, 1'b1, 1'b0}},
        '{ROW_ITEM, KIND_ADVANCE, 12'd0, 12'd0, 1'b0, 13'd0, 1'b1,
          {12'd0, 12'd1, 1'b1, 1'b0}},
        '{ROW_ITEM, KIND_ADVANCE, 12'h000, 12'hFFF, 1'b0, 13'd0, 1'b0, PIX_NONE},
        '{ROW_ITEM, KIND_ADVANCE, 12'hFFF, 12'h000, 1'b0, 13'd0, 1'b0, PIX_NONE},
        '{ROW_ITEM, KIND_START, 12'hFFF, 12'hFFF, 1'b0, 13'd0, 1'b1,
          {12'd639, 12'd479, 1'b1, 1'b0}},
        '{ROW_ITEM, KIND_ADVANCE, 12'd0, 12'd0, 1'b0, 13'd0, 1'b0, PIX_NONE},
        '{ROW_CFG, KIND_ADVANCE, 12'd0, 12'd0, CFG_FRAME_WIDTH, 13'd0, 1'b0, PIX_NONE},
        '{ROW_CFG, KIND_ADVANCE, 12'd0, 12'd0, CFG_FRAME_HEIGHT, 13'd0, 1'b0, PIX_NONE},
        '{ROW_ITEM, KIND_START, 12'hAAA, 12'h555, 1'b0, 13'd0, 1'b1,
          {12'd0, 12'd0, 1'b1, 1'b0}},
        '{ROW_ITEM, KIND_ADVANCE, 12'd0, 12'd0, 1'b0, 13'd0, 1'b1, PIX_DONE},
        '{ROW_ITEM, KIND_ADVANCE, 12'd0, 12'd0, 1'b0, 13'd0, 1'b1, PIX_DONE},
        '{ROW_CFG, KIND_ADVANCE, 12'd0, 12'd0, CFG_FRAME_WIDTH, 13'h1FFF, 1'b0, PIX_NONE},
        '{ROW_CFG, KIND_ADVANCE, 12'd0, 12'd0, CFG_FRAME_HEIGHT, 13'd4096, 1'b0, PIX_NONE},
        '{ROW_ITEM, KIND_START, 12'hFFF, 12'hFFF, 1'b0, 13'd0, 1'b1,
          {12'd4095, 12'd4095, 1'b1, 1'b0}},
        '{ROW_ITEM, KIND_ADVANCE, 12'd0, 12'd0, 1'b0, 13'd0, 1'b1,
          {12'd4094, 12'd4095, 1'b1, 1'b0}},
        '{ROW_ITEM, KIND_START, 12'h555, 12'hAAA, 1'b0, 13'd0, 1'b1,
          {12'h555, 12'hAAA, 1'b1, 1'b0}},
        '{ROW_ITEM, KIND_ADVANCE, 12'd0, 12'd0, 1'b0, 13'd0, 1'b0, PIX_NONE},
        '{ROW_CFG, KIND_ADVANCE, 12'd0, 12'd0, CFG_FRAME_WIDTH, 13'd2, 1'b0, PIX_NONE},
        '{ROW_ITEM, KIND_ADVANCE, 12'd0, 12'd0, 1'b0, 13'd0, 1'b0, PIX_NONE},
        '{ROW_ITEM, KIND_ADVANCE, 12'd0, 12'd0, 1'b0, 13'd0, 1'b0, PIX_NONE},
        '{ROW_ITEM, KIND_ADVANCE, 12'd0, 12'd0, 1'b0, 13'd0, 1'b0, PIX_NONE},
        '{ROW_CFG, KIND_ADVANCE, 12'd0, 12'd0, CFG_FRAME_HEIGHT, 13'd3, 1'b0, PIX_NONE},
        '{ROW_ITEM, KIND_START, 12'd0, 12'd2, 1'b0, 13'd0, 1'b1,
          {12'd0, 12'd2, 1'b1, 1'b0}},
        '{ROW_ITEM, KIND_ADVANCE, 12'd0, 12'd0, 1'b0, 13'd0, 1'b0, PIX_NONE},
        '{ROW_ITEM, KIND_ADVANCE, 12'd0, 12'd0, 1'b0, 13'd0, 1'b0, PIX_NONE},
        '{ROW_ITEM, KIND_ADVANCE, 12'd0, 12'd0, 1'b0, 13'd0, 1'b0, PIX_NONE},
        '{ROW_ITEM, KIND_ADVANCE, 12'd0, 12'd0, 1'b0, 13'd0, 1'b0, PIX_NONE},
        '{ROW_ITEM, KIND_ADVANCE, 12'd0, 12'd0, 1'b0, 13'd0, 1'b0, PIX_NONE},
        '{ROW_ITEM, KIND_ADVANCE, 12'd0, 12'd0, 1'b0, 13'd0, 1'b0, PIX_NONE},
        '{ROW_ITEM, KIND_ADVANCE, 12'hFFF, 12'hFFF, 1'b0, 13'd0, 1'b0, PIX_NONE}
    };

    // stimulus: reset, directed rows, then random spirals
    initial begin : stim_gen
        bit               first;
        bit               quiet;
        int               area;
        int               n_items;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        scan_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].op == ROW_CFG) begin
                write_frame_reg(dir_rows[r].cfg_idx, dir_rows[r].cfg_data);
            end else begin
                idle_in(pick_gap(1'b0));
                send_item(dir_rows[r].kind, dir_rows[r].sx, dir_rows[r].sy,
                          dir_rows[r].typed, dir_rows[r].want);
            end
        end

        first = 1'b1;
        while (n_sent < RAND_ITEMS) begin
            // new frame size now and then, sometimes while a spiral is running
            if (first || $urandom_range(0, 2) == 0) begin
                if (first || $urandom_range(0, 1)) write_frame_reg(CFG_FRAME_WIDTH, pick_dim());
                if (first || $urandom_range(0, 1)) write_frame_reg(CFG_FRAME_HEIGHT, pick_dim());
                first = 1'b0;
            end
            quiet = ($urandom_range(0, 3) == 0);
            area  = frame_span(drv_w) * frame_span(drv_h);
            if ($urandom_range(0, 6) == 0) begin
                // noise: random kinds and coordinates
                n_items = $urandom_range(1, 12);
                for (int k = 0; k < n_items; k++) begin
                    idle_in(pick_gap(quiet));
                    send_item(1'($urandom_range(0, 1)), 12'($urandom()), 12'($urandom()),
                              1'b0, PIX_NONE);
                end
            end else begin
                // one spiral, usually walked to its end on small frames
                if ($urandom_range(0, 9) != 0) begin
                    if ($urandom_range(0, 2) == 0) begin
                        sx = 12'($urandom());
                        sy = 12'($urandom());
                    end else begin
                        sx = 12'($urandom_range(0, frame_span(drv_w) - 1));
                        sy = 12'($urandom_range(0, frame_span(drv_h) - 1));
                    end
                    idle_in(pick_gap(quiet));
                    send_item(KIND_START, sx, sy, 1'b0, PIX_NONE);
                end
                if (area <= 700)
                    n_items = ($urandom_range(0, 4) == 0) ? $urandom_range(1, area)
                                                           : area + $urandom_range(0, 3);
                else
                    n_items = $urandom_range(1, 60);
                for (int k = 0; k < n_items; k++) begin
                    idle_in(pick_gap(quiet));
                    send_item(KIND_ADVANCE, 12'($urandom()), 12'($urandom()), 1'b0, PIX_NONE);
                end
            end
        end

        // drain and settle
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_pixels.size() != 0);
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0 && pending_pixels.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
